FILE: hdl/tgrq_pkg.sv
// Package for the track grouped request queue.
// Holds the command and status codes, field widths and the cell structs.
// No dependencies.
package tgrq_pkg;

    localparam int TRACK_W = 10;
    localparam int ID_W    = 16;
    localparam int OCC_W   = 5;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic               valid;
        logic [TRACK_W-1:0] track;
        logic [ID_W-1:0]    id;
    } cell_data_t;

    typedef struct packed {
        logic seen;
        logic shift;
    } chain_t;

    typedef struct packed {
        logic               ins;
        logic               rem;
        logic [TRACK_W-1:0] track;
        logic [ID_W-1:0]    id;
    } cell_ctrl_t;

endpackage

FILE: hdl/tgrq_if.sv
// Handshake interfaces for the request and response channels.
// Depends on tgrq_pkg.
interface tgrq_req_if
    import tgrq_pkg::*;
();
    logic               valid;
    logic               ready;
    cmd_t               command;
    logic [TRACK_W-1:0] track;
    logic [ID_W-1:0]    request_id;

    modport source (output valid, command, track, request_id, input ready);
    modport sink   (input valid, command, track, request_id, output ready);
endinterface

interface tgrq_rsp_if
    import tgrq_pkg::*;
();
    logic               valid;
    logic               ready;
    status_t            status;
    logic [ID_W-1:0]    out_id;
    logic [TRACK_W-1:0] out_track;
    logic [OCC_W-1:0]   occupancy;

    modport source (output valid, status, out_id, out_track, occupancy, input ready);
    modport sink   (input valid, status, out_id, out_track, occupancy, output ready);
endinterface

FILE: hdl/tgrq_cell.sv
// One queue slot: holds a track and id, finds the insert point via the chain.
// Depends on tgrq_pkg.
module tgrq_cell
    import tgrq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  chain_t     chain_in,
    output chain_t     chain_out,
    input  cell_data_t left,
    input  cell_data_t right,
    output cell_data_t data
);

    logic               valid_reg;
    logic               valid_next;
    logic [TRACK_W-1:0] track_reg;
    logic [TRACK_W-1:0] track_next;
    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    id_next;
    logic               match;
    logic               here;

    assign match = valid_reg && (track_reg == ctrl.track);
    assign here  = !chain_in.shift && !match && (chain_in.seen || !valid_reg);

    assign chain_out.seen  = chain_in.seen | match;
    assign chain_out.shift = chain_in.shift | here;

    assign data.valid = valid_reg;
    assign data.track = track_reg;
    assign data.id    = id_reg;

    always_comb
    begin
        valid_next = valid_reg;
        track_next = track_reg;
        id_next    = id_reg;
        if (ctrl.ins)
        begin
            if (chain_in.shift)
            begin
                valid_next = left.valid;
                track_next = left.track;
                id_next    = left.id;
            end
            else if (here)
            begin
                valid_next = 1'b1;
                track_next = ctrl.track;
                id_next    = ctrl.id;
            end
        end
        else if (ctrl.rem)
        begin
            valid_next = right.valid;
            track_next = right.track;
            id_next    = right.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        track_reg <= track_next;
        id_reg    <= id_next;
    end

endmodule

FILE: hdl/track_grouped_request_queue.sv
// Top level of the track grouped request queue: a row of tgrq_cell slots,
// the fill count and the response register. Depends on tgrq_pkg, tgrq_if.
//
//  channel  dir  payload                                   handshake
//  req      in   command, track, request_id                valid/ready
//  rsp      out  status, out_id, out_track, occupancy      valid/ready
//
// One item per cycle; the response appears the cycle after the item is taken.
// The insert point is found along the cell chain, so the row length sets the
// critical path. Reset empties the queue at once, no clearing pass.
// A stalled response blocks new items; ready comes back as it is taken.
module track_grouped_request_queue
    import tgrq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    tgrq_req_if.sink   req,
    tgrq_rsp_if.source rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    cell_data_t         cell_data [DEPTH];
    chain_t             chain     [DEPTH+1];
    cell_ctrl_t         ctrl;
    cell_data_t         edge_fill;
    logic               fire;
    logic               full;
    logic               empty;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    status_t            status_reg;
    status_t            status_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [ID_W-1:0]    out_id_next;
    logic [TRACK_W-1:0] out_track_reg;
    logic [TRACK_W-1:0] out_track_next;
    logic [OCC_W-1:0]   occ_reg;
    logic [OCC_W-1:0]   occ_next;

    assign full  = cell_data[DEPTH-1].valid;
    assign empty = !cell_data[0].valid;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign fire      = req.valid && req.ready;

    assign ctrl.ins   = fire && (req.command == CMD_INSERT) && !full;
    assign ctrl.rem   = fire && (req.command == CMD_REMOVE) && !empty;
    assign ctrl.track = req.track;
    assign ctrl.id    = req.request_id;

    assign edge_fill = '0;
    assign chain[0]  = '0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            tgrq_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .chain_in  (chain[g]),
                .chain_out (chain[g+1]),
                .left      ((g == 0) ? edge_fill : cell_data[(g == 0) ? 0 : g-1]),
                .right     ((g == DEPTH-1) ? edge_fill
                                           : cell_data[(g == DEPTH-1) ? g : g+1]),
                .data      (cell_data[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        out_track_next = out_track_reg;
        occ_next       = occ_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctrl.ins)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctrl.rem)
        begin
            count_next = count_reg - CW'(1);
        end
        if (fire)
        begin
            rsp_valid_next = 1'b1;
            out_id_next    = '0;
            out_track_next = '0;
            status_next    = ST_DONE;
            case (req.command)
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                end
                CMD_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_id_next    = cell_data[0].id;
                        out_track_next = cell_data[0].track;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
            occ_next = OCC_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        out_id_reg    <= out_id_next;
        out_track_reg <= out_track_next;
        occ_reg       <= occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.out_id    = out_id_reg;
    assign rsp.out_track = out_track_reg;
    assign rsp.occupancy = occ_reg;

`ifndef SYNTHESIS
    a_empty_count : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == empty)
        else $error("fill count disagrees with head cell");

    a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (count_reg == CW'(DEPTH)))
        else $error("last cell occupied but count not at depth");

    a_remove_rsp : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rem |=> (rsp_valid_reg && (status_reg == ST_DONE)
                      && (count_reg == $past(count_reg) - CW'(1))))
        else $error("remove did not pop the head");

    a_ins_sites : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.ins && !full) |-> chain[DEPTH].shift)
        else $error("insert found no free slot");
`endif

endmodule

FILE: bench/track_grouped_request_queue_tb.sv
// Testbench for track_grouped_request_queue: directed and random request items
// checked against a track-grouping queue predictor held in a scoreboard class.
// Depends on tgrq_pkg, tgrq_if and the track_grouped_request_queue RTL.
`timescale 1ns / 1ps

import tgrq_pkg::*;

class request_queue_scoreboard;

    typedef struct {
        status_t            status;
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] trk;
        logic [OCC_W-1:0]   occ;
    } response_t;

    logic [TRACK_W-1:0] slot_trk[$];
    logic [ID_W-1:0]    slot_rid[$];
    response_t          response_q[$];
    int                 depth;
    int                 errors;

    function new(int d);
        depth  = d;
        errors = 0;
    endfunction

    function int pending();
        return response_q.size();
    endfunction

    function void note_request(cmd_t c, logic [TRACK_W-1:0] t, logic [ID_W-1:0] r);
        response_t o;
        int        pos;
        o.status = ST_DONE;
        o.id     = '0;
        o.trk    = '0;
        if (c == CMD_INSERT)
        begin
            if (slot_trk.size() >= depth)
            begin
                o.status = ST_FULL;
            end
            else
            begin
                pos = slot_trk.size();
                for (int k = 0; k < slot_trk.size(); k++)
                begin
                    if (slot_trk[k] == t)
                    begin
                        pos = k + 1;
                        while (pos < slot_trk.size() && slot_trk[pos] == t)
                            pos++;
                        break;
                    end
                end
                slot_trk.insert(pos, t);
                slot_rid.insert(pos, r);
            end
        end
        else
        begin
            if (slot_trk.size() == 0)
            begin
                o.status = ST_EMPTY;
            end
            else
            begin
                o.id  = slot_rid.pop_front();
                o.trk = slot_trk.pop_front();
            end
        end
        o.occ = OCC_W'(slot_trk.size());
        response_q.push_back(o);
    endfunction

    function void check_response(status_t s, logic [ID_W-1:0] id,
                                 logic [TRACK_W-1:0] trk, logic [OCC_W-1:0] occ);
        response_t o;
        if (response_q.size() == 0)
        begin
            $error("response item with no request outstanding");
            errors++;
            return;
        end
        o = response_q.pop_front();
        if (s !== o.status)
        begin
            $error("status: expected %0d, got %0d", o.status, s);
            errors++;
        end
        if (id !== o.id)
        begin
            $error("out_id: expected %h, got %h", o.id, id);
            errors++;
        end
        if (trk !== o.trk)
        begin
            $error("out_track: expected %h, got %h", o.trk, trk);
            errors++;
        end
        if (occ !== o.occ)
        begin
            $error("occupancy: expected %0d, got %0d", o.occ, occ);
            errors++;
        end
    endfunction

endclass

module track_grouped_request_queue_tb;

    localparam int QDEPTH = 16;

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;

    request_queue_scoreboard sb;

    tgrq_req_if req();
    tgrq_rsp_if rsp();

    track_grouped_request_queue #(.DEPTH(QDEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    task automatic send_request(cmd_t c, logic [TRACK_W-1:0] t, logic [ID_W-1:0] r);
        bit taken;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.command    <= c;
        req.track      <= t;
        req.request_id <= r;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end
        sb.note_request(c, t, r);
    endtask

    task automatic run_phase(int src_pct, int snk_pct, int n);
        logic [TRACK_W-1:0] pool[4];
        int                 insert_pct;
        cmd_t               c;
        logic [TRACK_W-1:0] t;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        insert_pct   = 50;
        for (int k = 0; k < 4; k++)
            pool[k] = TRACK_W'($urandom_range(1023));
        for (int n_done = 0; n_done < n; n_done++)
        begin
            // shift the insert/remove mix to walk the queue between empty and full
            if (n_done % 48 == 0)
            begin
                case ($urandom_range(2))
                    0:       insert_pct = 25;
                    1:       insert_pct = 50;
                    default: insert_pct = 80;
                endcase
            end
            if (n_done % 32 == 0)
                pool[$urandom_range(3)] = TRACK_W'($urandom_range(1023));
            c = ($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            if ($urandom_range(99) < 80)
                t = pool[$urandom_range(3)];
            else
                t = TRACK_W'($urandom_range(1023));
            send_request(c, t, ID_W'($urandom_range(65535)));
        end
        req.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
                sb.check_response(rsp.status, rsp.out_id, rsp.out_track, rsp.occupancy);
        end
    end

    initial
    begin
        #2000000;
        $display("track_grouped_request_queue verification failed");
        $finish;
    end

    initial
    begin
        sb = new(QDEPTH);
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.command    <= CMD_INSERT;
        req.track      <= '0;
        req.request_id <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(CMD_REMOVE, 10'h3FF, 16'hFFFF);
        send_request(CMD_INSERT, 10'h000, 16'h0000);
        send_request(CMD_INSERT, 10'h3FF, 16'hFFFF);
        send_request(CMD_INSERT, 10'h000, 16'h0001);
        send_request(CMD_INSERT, 10'h005, 16'h0002);
        send_request(CMD_INSERT, 10'h3FF, 16'h0003);
        for (int k = 0; k < 11; k++)
            send_request(CMD_INSERT, (k % 3 == 0) ? 10'h2AA : 10'h155, 16'h5555 ^ ID_W'(k));
        send_request(CMD_INSERT, 10'h000, 16'hAAAA);
        for (int k = 0; k < 4; k++)
            send_request(CMD_REMOVE, 10'h3FF, 16'hFFFF);
        send_request(CMD_INSERT, 10'h155, 16'h1234);
        req.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);

        run_phase(38, 63, 417);
        run_phase(63, 38, 417);
        run_phase(0, 0, 416);

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("track_grouped_request_queue verification clean");
        else
            $display("track_grouped_request_queue verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tgrq_pkg.sv
hdl/tgrq_if.sv
hdl/tgrq_cell.sv
hdl/track_grouped_request_queue.sv
bench/track_grouped_request_queue_tb.sv
